### sv/lyti_pkg.sv
`timescale 1ns / 1ps

package lyti_pkg;

   // Sizing of the table store.
   localparam int NUM_TABLES = 4;
   localparam int NUM_POINTS = 64;
   localparam int VALUE_W    = 24;
   localparam int TBL_W      = 2;
   localparam int IDX_W      = 6;
   localparam int KIND_W     = 2;
   localparam int LIGHT_W    = VALUE_W + 1;
   localparam int STAT_W     = 2;
   localparam int LEN_W      = $clog2(NUM_POINTS + 1);
   localparam int ADDR_W     = $clog2(NUM_TABLES * NUM_POINTS);
   localparam int CNT_W      = $clog2(VALUE_W);

   // Request type codes.
   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_code_type;

   // Particle kind codes; any other code has no table.
   typedef enum logic [KIND_W-1:0] {
      KIND_ELECTRON = 2'd0,
      KIND_TABLED   = 2'd1
   } kind_code_type;

   // Response status codes.
   typedef enum logic [STAT_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_TABLE = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_code_type;

   // Selects what goes into the response registers.
   typedef enum logic [2:0] {
      RES_ZERO_OK,
      RES_NO_TABLE,
      RES_EMPTY,
      RES_ELECTRON,
      RES_DIFF
   } res_code_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         capture;
      logic         write;
      logic         phase;
      logic         scan_init;
      logic         scan_step;
      logic         mul;
      logic         div_step;
      logic         take_zero;
      logic         take_end;
      logic         take_interp;
      logic         set_res;
      res_code_type res_code;
   } lyti_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_load;
      logic is_electron;
      logic is_tabled;
      logic table_ok;
      logic table_empty;
      logic e_nonpos;
      logic found;
      logic exhausted;
      logic div_last;
   } lyti_stat_type;

endpackage

### sv/lyti_ctrl.sv
`timescale 1ns / 1ps

module lyti_ctrl import lyti_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output logic          rsp_valid,
   input  lyti_stat_type stat,
   output lyti_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LK_START,
      ST_SCAN,
      ST_MUL,
      ST_DIV,
      ST_LK_FIN,
      ST_LK_DONE
   } state_type;

   // The response cycle is marked by out_ff so that the strobe lasts one cycle.
   state_type state_ff, state_in;
   logic      out_ff, out_in;
   logic      phase_ff, phase_in;
   logic      valid_ff;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      out_in   = 1'b0;
      cmd      = '0;
      cmd.res_code = RES_ZERO_OK;
      cmd.phase    = phase_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && !out_ff) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in    = ST_IDLE;
            out_in      = 1'b1;
            cmd.set_res = 1'b1;
            phase_in    = 1'b0;
            priority if (stat.is_load) begin
               cmd.write    = 1'b1;
               cmd.res_code = RES_ZERO_OK;
            end else if (stat.is_electron) begin
               cmd.res_code = RES_ELECTRON;
            end else if (!stat.is_tabled || !stat.table_ok) begin
               cmd.res_code = RES_NO_TABLE;
            end else if (stat.table_empty) begin
               cmd.res_code = RES_EMPTY;
            end else begin
               cmd.set_res = 1'b0;
               out_in      = 1'b0;
               state_in    = ST_LK_START;
            end
         end
         ST_LK_START: begin
            cmd.scan_init = 1'b1;
            if (stat.e_nonpos) begin
               cmd.take_zero = 1'b1;
               state_in      = ST_LK_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            priority if (stat.found) begin
               state_in = ST_MUL;
            end else if (stat.exhausted) begin
               cmd.take_end = 1'b1;
               state_in     = ST_LK_DONE;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_LK_FIN;
            end
         end
         ST_LK_FIN: begin
            cmd.take_interp = 1'b1;
            state_in        = ST_LK_DONE;
         end
         ST_LK_DONE: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
               state_in = ST_LK_START;
            end else begin
               cmd.set_res  = 1'b1;
               cmd.res_code = RES_DIFF;
               out_in       = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, lookup phase and the response strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
         out_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         out_ff   <= out_in;
         valid_ff <= out_in;
      end
   end

   // Busy covers the work and the response cycle.
   assign busy      = (state_ff != ST_IDLE) || out_ff;
   assign rsp_valid = valid_ff;

endmodule

### sv/lyti_dpath.sv
`timescale 1ns / 1ps

module lyti_dpath import lyti_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  lyti_cmd_type               cmd,
   output lyti_stat_type              stat,
   input  logic                       req_type,
   input  logic [TBL_W-1:0]           req_table_id,
   input  logic [IDX_W-1:0]           req_point_index,
   input  logic [VALUE_W-1:0]         req_point_energy,
   input  logic [VALUE_W-1:0]         req_point_light,
   input  logic                       req_last_point,
   input  logic [KIND_W-1:0]          req_particle_kind,
   input  logic [VALUE_W-1:0]         req_initial_energy,
   input  logic [VALUE_W-1:0]         req_deposited_energy,
   output logic signed [LIGHT_W-1:0]  rsp_light_value,
   output logic [STAT_W-1:0]          rsp_status
);

   // Captured request.
   logic                type_ff;
   logic [TBL_W-1:0]    tbl_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [VALUE_W-1:0]  pe_ff;
   logic [VALUE_W-1:0]  pl_ff;
   logic                last_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [VALUE_W-1:0]  ie_ff;
   logic [VALUE_W-1:0]  de_ff;

   // Point store, one entry holds energy over light.
   logic [2*VALUE_W-1:0] mem [NUM_TABLES*NUM_POINTS];
   logic [2*VALUE_W-1:0] rd_ff;
   logic [LEN_W-1:0]     len_ff [NUM_TABLES];

   // Scan, interpolation and divider registers.
   logic [LEN_W-1:0]         k_ff;
   logic                     pend_ff;
   logic [VALUE_W-1:0]       xl_ff, yl_ff;
   logic [VALUE_W-1:0]       den_ff, span_ff, dmag_ff;
   logic                     dneg_ff;
   logic [VALUE_W-1:0]       rem_ff, qsh_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic signed [LIGHT_W-1:0] lka_ff, lkb_ff;
   logic signed [LIGHT_W-1:0] light_ff;
   logic [STAT_W-1:0]        status_ff;

   logic signed [LIGHT_W-1:0] e_val;
   logic [VALUE_W-1:0]        e_low;
   logic [VALUE_W-1:0]        rd_e, rd_l;
   logic [LEN_W-1:0]          len_cur;
   logic                      above;
   logic                      tbl_ok, idx_ok;
   logic [ADDR_W-1:0]         rd_addr, wr_addr;
   logic [2*VALUE_W-1:0]      prod;
   logic [VALUE_W:0]          trial;
   logic                      trial_ge;
   logic signed [LIGHT_W-1:0] interp;
   logic signed [LIGHT_W-1:0] lk_new;

   assign tbl_ok = (32'(tbl_ff) < NUM_TABLES);
   assign idx_ok = (32'(idx_ff) < NUM_POINTS);
   assign len_cur = len_ff[tbl_ff];

   // Energy looked up in this phase: initial, then initial minus deposited.
   assign e_val = cmd.phase ? ($signed({1'b0, ie_ff}) - $signed({1'b0, de_ff}))
                            : $signed({1'b0, ie_ff});
   assign e_low = e_val[VALUE_W-1:0];

   assign rd_e  = rd_ff[2*VALUE_W-1:VALUE_W];
   assign rd_l  = rd_ff[VALUE_W-1:0];
   assign above = rd_e > e_low;

   assign rd_addr = ADDR_W'(32'(tbl_ff) * NUM_POINTS + 32'(k_ff[IDX_W-1:0]));
   assign wr_addr = ADDR_W'(32'(tbl_ff) * NUM_POINTS + 32'(idx_ff));

   // Status toward the controller.
   always_comb begin
      stat             = '0;
      stat.is_load     = (type_ff == REQ_LOAD);
      stat.is_electron = (kind_ff == KIND_ELECTRON);
      stat.is_tabled   = (kind_ff == KIND_TABLED);
      stat.table_ok    = tbl_ok;
      stat.table_empty = (len_cur == '0);
      stat.e_nonpos    = e_val[LIGHT_W-1] || (e_val == '0);
      stat.found       = pend_ff && above;
      stat.exhausted   = pend_ff && !above && (k_ff == len_cur);
      stat.div_last    = (cnt_ff == CNT_W'(VALUE_W - 1));
   end

   // Multiplier feeding the divider, and one restoring divide step.
   assign prod     = (2*VALUE_W)'(dmag_ff) * (2*VALUE_W)'(span_ff);
   assign trial    = {rem_ff, qsh_ff[VALUE_W-1]};
   assign trial_ge = trial >= {1'b0, den_ff};

   assign interp = dneg_ff ? ($signed({1'b0, yl_ff}) - $signed({1'b0, qsh_ff}))
                           : ($signed({1'b0, yl_ff}) + $signed({1'b0, qsh_ff}));

   // Value of a finished lookup.
   always_comb begin
      priority if (cmd.take_end) begin
         lk_new = $signed({1'b0, rd_l});
      end else if (cmd.take_interp) begin
         lk_new = interp;
      end else begin
         lk_new = '0;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_type;
         tbl_ff  <= req_table_id;
         idx_ff  <= req_point_index;
         pe_ff   <= req_point_energy;
         pl_ff   <= req_point_light;
         last_ff <= req_last_point;
         kind_ff <= req_particle_kind;
         ie_ff   <= req_initial_energy;
         de_ff   <= req_deposited_energy;
      end
   end

   // Point store with registered read.
   always_ff @(posedge clock) begin
      if (cmd.write && tbl_ok && idx_ok) begin
         mem[wr_addr] <= {pe_ff, pl_ff};
      end
      rd_ff <= mem[rd_addr];
   end

   // Table lengths clear on reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TABLES; i++) begin
            len_ff[i] <= '0;
         end
      end else if (cmd.write && tbl_ok && idx_ok && last_ff) begin
         len_ff[tbl_ff] <= LEN_W'(idx_ff) + LEN_W'(1);
      end
   end

   // Linear scan for the first point above the energy.
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= '0;
         pend_ff <= 1'b0;
      end else if (cmd.scan_init) begin
         k_ff    <= '0;
         pend_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (!(pend_ff && above) && (k_ff < len_cur)) begin
            k_ff    <= k_ff + LEN_W'(1);
            pend_ff <= 1'b1;
         end else begin
            pend_ff <= 1'b0;
         end
      end
   end

   // Lower point tracking and segment setup when the upper point is found.
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         xl_ff <= '0;
         yl_ff <= '0;
      end else if (cmd.scan_step && pend_ff) begin
         if (!above) begin
            xl_ff <= rd_e;
            yl_ff <= rd_l;
         end else begin
            den_ff  <= rd_e - xl_ff;
            span_ff <= e_low - xl_ff;
            dneg_ff <= rd_l < yl_ff;
            dmag_ff <= (rd_l < yl_ff) ? (yl_ff - rd_l) : (rd_l - yl_ff);
         end
      end
   end

   // Product loads the divider; the quotient is known to fit one value width.
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         rem_ff <= prod[2*VALUE_W-1:VALUE_W];
         qsh_ff <= prod[VALUE_W-1:0];
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= trial_ge ? VALUE_W'(trial - {1'b0, den_ff}) : trial[VALUE_W-1:0];
         qsh_ff <= {qsh_ff[VALUE_W-2:0], trial_ge};
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // Lookup results for both phases.
   always_ff @(posedge clock) begin
      if (cmd.take_zero || cmd.take_end || cmd.take_interp) begin
         if (cmd.phase) begin
            lkb_ff <= lk_new;
         end else begin
            lka_ff <= lk_new;
         end
      end
   end

   // Response registers.
   always_ff @(posedge clock) begin
      if (cmd.set_res) begin
         unique case (cmd.res_code)
            RES_ZERO_OK: begin
               light_ff  <= '0;
               status_ff <= STATUS_OK;
            end
            RES_NO_TABLE: begin
               light_ff  <= '0;
               status_ff <= STATUS_NO_TABLE;
            end
            RES_EMPTY: begin
               light_ff  <= '0;
               status_ff <= STATUS_EMPTY;
            end
            RES_ELECTRON: begin
               light_ff  <= $signed({1'b0, de_ff});
               status_ff <= STATUS_OK;
            end
            RES_DIFF: begin
               light_ff  <= lka_ff - lkb_ff;
               status_ff <= STATUS_OK;
            end
            default: begin
               light_ff  <= '0;
               status_ff <= STATUS_OK;
            end
         endcase
      end
   end

   assign rsp_light_value = light_ff;
   assign rsp_status      = status_ff;

endmodule

### sv/light_yield_table_interpolator.sv
`timescale 1ns / 1ps
// A request that needs no lookup is decoded and answered without a scan; a tabled query
// runs two lookups, each a linear scan over the points read from the store, then a
// multiply and a bit-serial divide.
// Busy covers the response cycle, so the next request is taken in the cycle after it;
// no request is taken before the last one is answered. The receiver cannot stall the strobe.
// Reset clears the controller and the table lengths; table points are undefined until loaded.

module light_yield_table_interpolator import lyti_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_type,
   input  logic [TBL_W-1:0]           req_table_id,
   input  logic [IDX_W-1:0]           req_point_index,
   input  logic [VALUE_W-1:0]         req_point_energy,
   input  logic [VALUE_W-1:0]         req_point_light,
   input  logic                       req_last_point,
   input  logic [KIND_W-1:0]          req_particle_kind,
   input  logic [VALUE_W-1:0]         req_initial_energy,
   input  logic [VALUE_W-1:0]         req_deposited_energy,
   output logic                       rsp_valid,
   output logic signed [LIGHT_W-1:0]  rsp_light_value,
   output logic [STAT_W-1:0]          rsp_status
);

   lyti_cmd_type  cmd;
   lyti_stat_type stat;

   // Sequencer for one request.
   lyti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Table store, scan, multiply and divide.
   lyti_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_type             (req_type),
      .req_table_id         (req_table_id),
      .req_point_index      (req_point_index),
      .req_point_energy     (req_point_energy),
      .req_point_light      (req_point_light),
      .req_last_point       (req_last_point),
      .req_particle_kind    (req_particle_kind),
      .req_initial_energy   (req_initial_energy),
      .req_deposited_energy (req_deposited_energy),
      .rsp_light_value      (rsp_light_value),
      .rsp_status           (rsp_status)
   );

endmodule

### dv/lyti_checker.sv
`timescale 1ns / 1ps

// Watches the request and response channels of the light table interpolator,
// keeps its own copy of the light tables and checks every response in order.
module lyti_checker import lyti_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic                      req_type,
   input  logic [TBL_W-1:0]          req_table_id,
   input  logic [IDX_W-1:0]          req_point_index,
   input  logic [VALUE_W-1:0]        req_point_energy,
   input  logic [VALUE_W-1:0]        req_point_light,
   input  logic                      req_last_point,
   input  logic [KIND_W-1:0]         req_particle_kind,
   input  logic [VALUE_W-1:0]        req_initial_energy,
   input  logic [VALUE_W-1:0]        req_deposited_energy,
   input  logic                      rsp_valid,
   input  logic signed [LIGHT_W-1:0] rsp_light_value,
   input  logic [STAT_W-1:0]         rsp_status,
   output int                        error_count,
   output int                        outstanding
);

   typedef struct {
      logic signed [LIGHT_W-1:0] light;
      status_code_type           status;
   } light_result_type;

   // Shadow copy of the point store and the table lengths.
   logic [VALUE_W-1:0] pt_energy [NUM_TABLES*NUM_POINTS];
   logic [VALUE_W-1:0] pt_light  [NUM_TABLES*NUM_POINTS];
   logic [LEN_W-1:0]   seg_len   [NUM_TABLES];

   light_result_type light_due [$];
   int               fails = 0;

   // Piecewise linear light at energy e in table tbl; e at or below zero gives 0.
   function automatic longint light_at(logic [TBL_W-1:0] tbl, longint e);
      int unsigned       len;
      int unsigned       k;
      logic [ADDR_W-1:0] base;
      longint            xl;
      longint            yl;
      longint            xu;
      longint            yu;
      longint            den;
      len  = 32'(seg_len[tbl]);
      base = ADDR_W'(32'(tbl) * NUM_POINTS);
      xl   = 0;
      yl   = 0;
      if (e <= 0 || len == 0) return 0;
      k = 0;
      while (k < len && longint'(pt_energy[base + ADDR_W'(k)]) <= e) k++;
      // Past the last point the light is clamped to the last entry.
      if (k == len) return longint'(pt_light[base + ADDR_W'(len - 1)]);
      xu = longint'(pt_energy[base + ADDR_W'(k)]);
      yu = longint'(pt_light[base + ADDR_W'(k)]);
      if (k > 0) begin
         xl = longint'(pt_energy[base + ADDR_W'(k - 1)]);
         yl = longint'(pt_light[base + ADDR_W'(k - 1)]);
      end
      den = xu - xl;
      if (den <= 0) return yl;
      // Signed division truncates toward zero, as the block does.
      return yl + ((yu - yl) * (e - xl)) / den;
   endfunction

   // Applies one accepted request to the shadow state and returns its response.
   function automatic light_result_type apply_request();
      light_result_type  res;
      logic [ADDR_W-1:0] addr;
      longint            diff;
      res.light  = '0;
      res.status = STATUS_OK;
      if (req_type == REQ_LOAD) begin
         if (req_table_id < NUM_TABLES && req_point_index < NUM_POINTS) begin
            addr            = ADDR_W'(32'(req_table_id) * NUM_POINTS + 32'(req_point_index));
            pt_energy[addr] = req_point_energy;
            pt_light[addr]  = req_point_light;
            if (req_last_point) begin
               seg_len[req_table_id] = LEN_W'(req_point_index) + LEN_W'(1);
            end
         end
      end else if (req_particle_kind == KIND_ELECTRON) begin
         res.light = {1'b0, req_deposited_energy};
      end else if (req_particle_kind == KIND_TABLED) begin
         if (req_table_id >= NUM_TABLES) begin
            res.status = STATUS_NO_TABLE;
         end else if (seg_len[req_table_id] == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            diff = light_at(req_table_id, longint'(req_initial_energy)) -
                   light_at(req_table_id, longint'(req_initial_energy) -
                                          longint'(req_deposited_energy));
            res.light = diff[LIGHT_W-1:0];
         end
      end else begin
         res.status = STATUS_NO_TABLE;
      end
      return res;
   endfunction

   // Predict on each accepted request, then compare any response in order.
   always @(posedge clock) begin
      light_result_type due;
      if (reset) begin
         foreach (seg_len[t]) seg_len[t] = '0;
         light_due.delete();
      end else begin
         if (start && !busy) begin
            due       = apply_request();
            light_due = {light_due, due};
         end
         if (rsp_valid) begin
            if (light_due.size() == 0) begin
               $error("response with no request waiting: light_value %0d, status %0d",
                      rsp_light_value, rsp_status);
               fails++;
            end else begin
               due = light_due.pop_front();
               if (rsp_light_value !== due.light) begin
                  $error("light_value: expected %0d, got %0d", due.light, rsp_light_value);
                  fails++;
               end
               if (rsp_status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_status);
                  fails++;
               end
            end
         end
      end
      error_count <= fails;
      outstanding <= light_due.size();
   end

endmodule

### dv/tb_light_yield_table_interpolator.sv
`timescale 1ns / 1ps

// Drives loads and queries into the light table interpolator; the checker beside
// the block predicts and compares, and this module gives the verdict.
module tb_light_yield_table_interpolator;
   import lyti_pkg::*;

   localparam int unsigned VALUE_MAX = (1 << VALUE_W) - 1;
   localparam int          RANDOM_REQUESTS = 550;

   // Particle kinds that have no table.
   localparam logic [KIND_W-1:0] KIND_NONE     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

   typedef struct {
      req_code_type       op;
      logic [TBL_W-1:0]   tbl;
      logic [IDX_W-1:0]   idx;
      logic [VALUE_W-1:0] energy;
      logic [VALUE_W-1:0] light;
      logic               last;
      logic [KIND_W-1:0]  kind;
      logic [VALUE_W-1:0] initial_e;
      logic [VALUE_W-1:0] deposit;
   } lyti_request_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_type;
   logic [TBL_W-1:0]          req_table_id;
   logic [IDX_W-1:0]          req_point_index;
   logic [VALUE_W-1:0]        req_point_energy;
   logic [VALUE_W-1:0]        req_point_light;
   logic                      req_last_point;
   logic [KIND_W-1:0]         req_particle_kind;
   logic [VALUE_W-1:0]        req_initial_energy;
   logic [VALUE_W-1:0]        req_deposited_energy;
   logic                      rsp_valid;
   logic signed [LIGHT_W-1:0] rsp_light_value;
   logic [STAT_W-1:0]         rsp_status;
   int                        mismatches;
   int                        outstanding;

   // Which points of each table hold data, and the top energy of each table.
   bit [NUM_POINTS-1:0] filled [NUM_TABLES];
   int unsigned         hi_energy [NUM_TABLES];
   int                  sent = 0;
   int                  idle_pct = 0;
   int                  idle_plan [4] = '{0, 62, 0, 32};

   light_yield_table_interpolator u_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_type             (req_type),
      .req_table_id         (req_table_id),
      .req_point_index      (req_point_index),
      .req_point_energy     (req_point_energy),
      .req_point_light      (req_point_light),
      .req_last_point       (req_last_point),
      .req_particle_kind    (req_particle_kind),
      .req_initial_energy   (req_initial_energy),
      .req_deposited_energy (req_deposited_energy),
      .rsp_valid            (rsp_valid),
      .rsp_light_value      (rsp_light_value),
      .rsp_status           (rsp_status)
   );

   lyti_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_type             (req_type),
      .req_table_id         (req_table_id),
      .req_point_index      (req_point_index),
      .req_point_energy     (req_point_energy),
      .req_point_light      (req_point_light),
      .req_last_point       (req_last_point),
      .req_particle_kind    (req_particle_kind),
      .req_initial_energy   (req_initial_energy),
      .req_deposited_energy (req_deposited_energy),
      .rsp_valid            (rsp_valid),
      .rsp_light_value      (rsp_light_value),
      .rsp_status           (rsp_status),
      .error_count          (mismatches),
      .outstanding          (outstanding)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog for a hung block.
   initial begin
      #20_000_000;
      $display("tb_light_yield_table_interpolator: done, errors");
      $finish;
   end

   // Drives one request at a falling edge, after a random idle gap, and holds it
   // until the block accepts it.
   task automatic issue(input lyti_request_type rq);
      idle_pct = idle_plan[2'((sent / 100) % 4)];
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start                <= 1'b1;
      req_type             <= rq.op;
      req_table_id         <= rq.tbl;
      req_point_index      <= rq.idx;
      req_point_energy     <= rq.energy;
      req_point_light      <= rq.light;
      req_last_point       <= rq.last;
      req_particle_kind    <= rq.kind;
      req_initial_energy   <= rq.initial_e;
      req_deposited_energy <= rq.deposit;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent++;
   endtask

   // Loads one point; the particle fields carry random noise.
   task automatic load_point(input int unsigned tbl, input int unsigned idx,
                             input int unsigned energy, input int unsigned light,
                             input bit last);
      lyti_request_type rq;
      rq.op        = REQ_LOAD;
      rq.tbl       = TBL_W'(tbl);
      rq.idx       = IDX_W'(idx);
      rq.energy    = VALUE_W'(energy);
      rq.light     = VALUE_W'(light);
      rq.last      = last;
      rq.kind      = KIND_W'($urandom);
      rq.initial_e = VALUE_W'($urandom);
      rq.deposit   = VALUE_W'($urandom);
      filled[TBL_W'(tbl)][IDX_W'(idx)] = 1'b1;
      if (last) hi_energy[TBL_W'(tbl)] = energy & VALUE_MAX;
      issue(rq);
   endtask

   // Sends one query; the load fields carry random noise.
   task automatic query(input logic [KIND_W-1:0] kind, input int unsigned tbl,
                        input int unsigned initial_e, input int unsigned deposit);
      lyti_request_type rq;
      rq.op        = REQ_QUERY;
      rq.tbl       = TBL_W'(tbl);
      rq.idx       = IDX_W'($urandom);
      rq.energy    = VALUE_W'($urandom);
      rq.light     = VALUE_W'($urandom);
      rq.last      = 1'($urandom);
      rq.kind      = kind;
      rq.initial_e = VALUE_W'(initial_e);
      rq.deposit   = VALUE_W'(deposit);
      issue(rq);
   endtask

   // Writes a table of ascending energies from index 0; now and then the
   // sequence is cut short without its last-point flag.
   task automatic build_table();
      int unsigned tbl;
      int unsigned n;
      int unsigned step_max;
      int unsigned e;
      bit          cut;
      tbl = $urandom_range(NUM_TABLES - 1);
      n   = ($urandom_range(11) == 0) ? $urandom_range(9, NUM_POINTS) : $urandom_range(1, 8);
      if ($urandom_range(4) == 0) step_max = $urandom_range(1, 8);
      else step_max = $urandom_range(1, VALUE_MAX / n);
      cut = ($urandom_range(7) == 0);
      e   = $urandom_range(0, step_max);
      for (int i = 0; i < n; i++) begin
         load_point(tbl, i, e, $urandom, (i == n - 1) && !cut);
         e += $urandom_range(1, step_max);
      end
   endtask

   // A load at a random place; the length only moves if this point and every lower point are written.
   task automatic stray_load();
      int unsigned     tbl;
      int unsigned     idx;
      bit [NUM_POINTS:0] need;
      bit              last;
      tbl  = $urandom_range(NUM_TABLES - 1);
      idx  = $urandom_range(NUM_POINTS - 1);
      need = ({{NUM_POINTS{1'b0}}, 1'b1} << (idx + 1)) - (NUM_POINTS + 1)'(1);
      last = ($urandom_range(3) == 0) &&
             ((filled[TBL_W'(tbl)] & need[NUM_POINTS-1:0]) == need[NUM_POINTS-1:0]);
      load_point(tbl, idx, $urandom, $urandom, last);
   endtask

   // A query aimed mostly inside the span of the chosen table.
   task automatic random_query();
      int unsigned         tbl;
      int unsigned         r;
      longint              cap;
      int unsigned         ie;
      int unsigned         de;
      logic [KIND_W-1:0]   kind;
      tbl = $urandom_range(NUM_TABLES - 1);
      r   = $urandom_range(9);
      if (r < 7) kind = KIND_TABLED;
      else if (r == 7) kind = KIND_ELECTRON;
      else if (r == 8) kind = KIND_NONE;
      else kind = KIND_RESERVED;
      cap = longint'(hi_energy[TBL_W'(tbl)]) + hi_energy[TBL_W'(tbl)] / 8 + 2;
      if (cap > VALUE_MAX) cap = VALUE_MAX;
      if ($urandom_range(4) == 0) ie = $urandom & VALUE_MAX;
      else ie = $urandom_range(0, int'(cap));
      r = $urandom_range(19);
      if (r < 14) de = $urandom_range(0, ie);
      else if (r < 17) de = $urandom_range(0, 3);
      else de = $urandom & VALUE_MAX;
      query(kind, tbl, ie, de);
   endtask

   // Stimulus and verdict.
   initial begin
      int base;
      reset                = 1'b1;
      start                = 1'b0;
      req_type             = REQ_LOAD;
      req_table_id         = '0;
      req_point_index      = '0;
      req_point_energy     = '0;
      req_point_light      = '0;
      req_last_point       = 1'b0;
      req_particle_kind    = KIND_ELECTRON;
      req_initial_energy   = '0;
      req_deposited_energy = '0;
      foreach (filled[t]) begin
         filled[t]    = '0;
         hi_energy[t] = 0;
      end
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Empty table, electrons at both extremes, and kinds without a table.
      query(KIND_TABLED, 0, 5000, 100);
      query(KIND_ELECTRON, 0, 0, VALUE_MAX);
      query(KIND_ELECTRON, 3, VALUE_MAX, 0);
      query(KIND_NONE, 1, 1000, 10);
      query(KIND_RESERVED, 3, VALUE_MAX, VALUE_MAX);

      // Table 0 with rising and falling segments and a full-scale light.
      load_point(0, 0, 100, 500, 1'b0);
      load_point(0, 1, 1000, VALUE_MAX, 1'b0);
      load_point(0, 2, 5000, 200, 1'b0);
      load_point(0, 3, 20000, 0, 1'b1);
      query(KIND_TABLED, 0, 0, 0);
      query(KIND_TABLED, 0, 50, 0);
      query(KIND_TABLED, 0, 100, 0);
      query(KIND_TABLED, 0, 3000, 2500);
      query(KIND_TABLED, 0, VALUE_MAX, 0);
      query(KIND_TABLED, 0, 10, VALUE_MAX);
      query(KIND_TABLED, 0, VALUE_MAX, VALUE_MAX);

      // An unsorted table still uses the first point above the energy.
      load_point(1, 0, 5000, 100, 1'b0);
      load_point(1, 1, 1000, 900, 1'b0);
      load_point(1, 2, 8000, 3000, 1'b1);
      query(KIND_TABLED, 1, 3000, 1000);

      // Shrinking a table moves the clamp point.
      load_point(0, 1, 1000, VALUE_MAX, 1'b1);
      query(KIND_TABLED, 0, 4000, 500);

      // Random part: tables built in order, stray loads, and mostly queries against them.
      base = sent;
      while (sent - base < RANDOM_REQUESTS) begin
         int unsigned sel;
         sel = $urandom_range(99);
         if (sel < 12) build_table();
         else if (sel < 22) stray_load();
         else random_query();
      end

      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("tb_light_yield_table_interpolator: done, clean");
      end else begin
         $display("tb_light_yield_table_interpolator: done, errors");
      end
      $finish;
   end

endmodule

### filelist.f
sv/lyti_pkg.sv
sv/lyti_ctrl.sv
sv/lyti_dpath.sv
sv/light_yield_table_interpolator.sv
dv/lyti_checker.sv
dv/tb_light_yield_table_interpolator.sv
